[sv/bal_pkg.sv]
// Shared types and constants for the buddy allocator unit.
// Used by bal_ctrl, bal_datapath and buddy_allocator_unit; depends on nothing.
package bal_pkg;

  localparam int OP_W    = 2;
  localparam int REQ_W   = 9;
  localparam int OFS_W   = 9;
  localparam int ST_W    = 2;
  localparam int GRANT_W = 8;
  localparam int BLK_W   = 9;
  localparam int NEED_W  = 10;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_BADOFS  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;
    logic            clr_step;
    logic            rd_node;
    logic            rd_left;
    logic            rd_sib;
    logic            descend;
    logic            climb;
    logic            mark;
    logic            merge;
    logic            finish;
    logic [ST_W-1:0] fin_status;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fits;
    logic at_need;
    logic is_zero;
    logic at_root;
    logic clr_last;
    logic ofs_ok;
    logic op_query;
  } dp_stat_t;

  // Smallest power of two not below the request; a request of zero counts as one.
  function automatic logic [NEED_W-1:0] round_up_pow2(input logic [REQ_W-1:0] req);
    logic [NEED_W-1:0] r;
    logic [NEED_W-1:0] p;
    r = (req == '0) ? NEED_W'(1) : NEED_W'(req);
    p = NEED_W'(1) << (NEED_W - 1);
    for (int i = NEED_W - 1; i >= 0; i--) begin
      if ((NEED_W'(1) << i) >= r) begin
        p = NEED_W'(1) << i;
      end
    end
    return p;
  endfunction

endpackage

[sv/buddy_allocator_unit.sv]
// Buddy allocator unit: one word in on start, one result word out on done.
// Built from bal_ctrl and bal_datapath; depends on bal_pkg.
//
// After reset the unit runs a clearing pass over all 2*P-1 tree nodes (P is UNITS rounded up
// to a power of two) and holds busy high meanwhile. A word is taken when start is
// high and busy is low. The tree is kept in one memory with one read and one write port;
// an allocate walks down the tree to a free block of the needed size and then back up,
// updating each level, a free climbs from the leaf to the allocated node, marks it free
// and merges back up, and a query climbs to the allocated node; an out-of-range offset
// or unused opcode is answered in the cycle after the word is taken, without a walk.
// done is high for exactly one cycle with status, granted_offset and block_units;
// there is no back-pressure on the result side, so it must be captured then.
module buddy_allocator_unit
  import bal_pkg::*;
#(
  parameter int UNITS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    opcode,
  input  logic [REQ_W-1:0]   request_units,
  input  logic [OFS_W-1:0]   block_offset,
  output logic               done,
  output logic [ST_W-1:0]    status,
  output logic [GRANT_W-1:0] granted_offset,
  output logic [BLK_W-1:0]   block_units
);

  localparam int LOG2P = $clog2(UNITS);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  bal_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  bal_datapath #(
    .LOG2P (LOG2P)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .opcode         (opcode),
    .request_units  (request_units),
    .block_offset   (block_offset),
    .cmd            (cmd),
    .stat           (stat),
    .done           (done),
    .status         (status),
    .granted_offset (granted_offset),
    .block_units    (block_units)
  );

  a_accept_then_work: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word neither started nor answered");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_NOSPACE || status == ST_BADOFS))
    else $error("undefined status code");
  a_fields_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (granted_offset == '0 && block_units == '0))
    else $error("result fields nonzero on a failed word");
  a_single_field: assert property (@(posedge clk) disable iff (rst)
    done |-> (granted_offset == '0 || block_units == '0))
    else $error("offset and block size reported together");

endmodule

[sv/bal_ctrl.sv]
// Sequencing state machine of the buddy allocator unit.
// Depends on bal_pkg; drives the command struct of bal_datapath.
module bal_ctrl
  import bal_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [OP_W-1:0] opcode,
  input  dp_stat_t        stat,
  output ctl_cmd_t        cmd,
  output logic            busy
);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_A_RD   = 11'b000_0000_0100,
    S_A_ROOT = 11'b000_0000_1000,
    S_A_STEP = 11'b000_0001_0000,
    S_A_DESC = 11'b000_0010_0000,
    S_F_RD   = 11'b000_0100_0000,
    S_F_CHK  = 11'b000_1000_0000,
    S_MARK   = 11'b001_0000_0000,
    S_UP_CHK = 11'b010_0000_0000,
    S_UP_MRG = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.fin_status = ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_ALLOC: begin
              cmd.load = 1'b1;
              state_next = S_A_RD;
            end
            OP_FREE, OP_QUERY: begin
              if (stat.ofs_ok) begin
                cmd.load = 1'b1;
                state_next = S_F_RD;
              end else begin
                cmd.finish = 1'b1;
                cmd.fin_status = ST_BADOFS;
              end
            end
            default: begin
              cmd.finish = 1'b1;
              cmd.fin_status = ST_BADOFS;
            end
          endcase
        end
      end
      S_A_RD: begin
        cmd.rd_node = 1'b1;
        state_next = S_A_ROOT;
      end
      S_A_ROOT: begin
        if (stat.fits) begin
          state_next = S_A_STEP;
        end else begin
          cmd.finish = 1'b1;
          cmd.fin_status = ST_NOSPACE;
          state_next = S_IDLE;
        end
      end
      S_A_STEP: begin
        if (stat.at_need) begin
          state_next = S_MARK;
        end else begin
          cmd.rd_left = 1'b1;
          state_next = S_A_DESC;
        end
      end
      S_A_DESC: begin
        cmd.descend = 1'b1;
        state_next = S_A_STEP;
      end
      S_F_RD: begin
        cmd.rd_node = 1'b1;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (stat.is_zero) begin
          if (stat.op_query) begin
            cmd.finish = 1'b1;
            cmd.fin_status = ST_OK;
            state_next = S_IDLE;
          end else begin
            state_next = S_MARK;
          end
        end else if (stat.at_root) begin
          cmd.finish = 1'b1;
          cmd.fin_status = ST_BADOFS;
          state_next = S_IDLE;
        end else begin
          cmd.climb = 1'b1;
          state_next = S_F_RD;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        state_next = S_UP_CHK;
      end
      S_UP_CHK: begin
        if (stat.at_root) begin
          cmd.finish = 1'b1;
          cmd.fin_status = ST_OK;
          state_next = S_IDLE;
        end else begin
          cmd.rd_sib = 1'b1;
          state_next = S_UP_MRG;
        end
      end
      S_UP_MRG: begin
        cmd.merge = 1'b1;
        state_next = S_UP_CHK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_clear_exits_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && stat.clr_last) |=> (state == S_IDLE))
    else $error("clearing pass did not end after the last node");
  a_one_memory_op: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.clr_step, cmd.mark, cmd.merge}) <= 1)
    else $error("two tree writes commanded in one cycle");
  a_finish_leaves_work: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && state != S_IDLE) |=> (state == S_IDLE))
    else $error("controller kept working after finishing a word");

endmodule

[sv/bal_datapath.sv]
// Tree memory, walk registers and result registers of the buddy allocator unit.
// Depends on bal_pkg; commanded by bal_ctrl.
module bal_datapath
  import bal_pkg::*;
#(
  parameter int LOG2P = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [OP_W-1:0]    opcode,
  input  logic [REQ_W-1:0]   request_units,
  input  logic [OFS_W-1:0]   block_offset,
  input  ctl_cmd_t           cmd,
  output dp_stat_t           stat,
  output logic               done,
  output logic [ST_W-1:0]    status,
  output logic [GRANT_W-1:0] granted_offset,
  output logic [BLK_W-1:0]   block_units
);

  localparam int P  = 1 << LOG2P;
  localparam int HW = LOG2P + 1;   // heap index, root at 1
  localparam int VW = LOG2P + 1;   // node value, 0 .. P
  localparam int CW = (VW > NEED_W) ? VW : NEED_W;
  localparam int OW = (HW > OFS_W) ? HW : OFS_W;

  logic [VW-1:0] tree_mem [1 << HW];

  logic [HW-1:0]     h;
  logic [VW-1:0]     size;
  logic [NEED_W-1:0] need;
  logic [LOG2P-1:0]  offset;
  logic [VW-1:0]     known;
  logic [OP_W-1:0]   op_reg;
  logic [VW-1:0]     rdata;

  logic [HW-1:0] raddr;
  logic          we;
  logic [HW-1:0] waddr;
  logic [VW-1:0] wdata;
  logic [HW-1:0] parent;
  logic [VW-1:0] psize;
  logic [VW:0]   pair_sum;
  logic [VW-1:0] pval;
  logic [VW-1:0] mark_val;
  logic [HW-1:0] h_inc;
  logic          fin_ok;

  assign parent   = h >> 1;
  assign psize    = size << 1;
  assign pair_sum = (VW + 1)'(known) + (VW + 1)'(rdata);
  // A parent whose two halves are wholly free becomes one free block again.
  assign pval     = (pair_sum == (VW + 1)'(psize)) ? psize :
                    ((known > rdata) ? known : rdata);
  assign mark_val = (op_reg == OP_ALLOC) ? '0 : size;
  assign h_inc    = h + HW'(1);
  assign fin_ok   = (cmd.fin_status == ST_OK);

  always_comb begin
    raddr = h;
    if (cmd.rd_left) begin
      raddr = {h[HW-2:0], 1'b0};
    end else if (cmd.rd_sib) begin
      raddr = h ^ HW'(1);
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = h;
    wdata = size;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.mark) begin
      we = 1'b1;
      wdata = mark_val;
    end else if (cmd.merge) begin
      we = 1'b1;
      waddr = parent;
      wdata = pval;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tree_mem[waddr] <= wdata;
    end
    rdata <= tree_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h    <= HW'(1);
      size <= VW'(P);
    end else if (cmd.clr_step) begin
      h <= h_inc;
      // Level size halves each time the index reaches a power of two.
      if ((h & h_inc) == '0) begin
        size <= size >> 1;
      end
    end else if (cmd.load) begin
      if (opcode == OP_ALLOC) begin
        h    <= HW'(1);
        size <= VW'(P);
      end else begin
        h    <= HW'(P) + HW'(block_offset);
        size <= VW'(1);
      end
    end else if (cmd.descend) begin
      h    <= {h[HW-2:0], ~stat.fits};
      size <= size >> 1;
    end else if (cmd.climb || cmd.merge) begin
      h    <= parent;
      size <= psize;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      need   <= round_up_pow2(request_units);
      op_reg <= opcode;
      offset <= '0;
    end else if (cmd.descend && !stat.fits) begin
      offset <= offset + LOG2P'(size >> 1);
    end
    if (cmd.mark) begin
      known <= mark_val;
    end else if (cmd.merge) begin
      known <= pval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status         <= cmd.fin_status;
      granted_offset <= (fin_ok && op_reg == OP_ALLOC) ? GRANT_W'(offset) : '0;
      block_units    <= (fin_ok && op_reg == OP_QUERY) ? BLK_W'(size) : '0;
    end
  end

  assign stat.fits     = (CW'(rdata) >= CW'(need));
  assign stat.at_need  = (CW'(size) == CW'(need));
  assign stat.is_zero  = (rdata == '0);
  assign stat.at_root  = (h == HW'(1));
  assign stat.clr_last = &h;
  assign stat.ofs_ok   = (OW'(block_offset) < OW'(P));
  assign stat.op_query = (op_reg == OP_QUERY);

  a_no_write_slot0: assert property (@(posedge clk) disable iff (rst)
    we |-> (waddr != '0))
    else $error("tree write to the unused slot");
  a_descend_below_root: assert property (@(posedge clk) disable iff (rst)
    cmd.descend |=> (h != HW'(1)))
    else $error("descent left the index at the root");
  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.mark || cmd.merge) |-> (size != '0))
    else $error("walk size collapsed to zero");

endmodule
